@@ hdl/icfp_pkg.sv @@
package icfp_pkg;

    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_DUTY = 8'h64;
    localparam logic [7:0] CH_FREQ = 8'h66;
    localparam logic [7:0] CH_LEN  = 8'h6C;
    localparam logic [7:0] CH_SIG  = 8'h73;

    typedef enum logic [3:0] {
        PH_VER   = 4'd0,
        PH_KEY_D = 4'd1,
        PH_DUTY  = 4'd2,
        PH_KEY_F = 4'd3,
        PH_FREQ  = 4'd4,
        PH_KEY_L = 4'd5,
        PH_LEN   = 4'd6,
        PH_KEY_S = 4'd7,
        PH_PAIRS = 4'd8,
        PH_END   = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        KIND_VERSION     = 3'd0,
        KIND_DUTY        = 3'd1,
        KIND_FREQUENCY   = 3'd2,
        KIND_LENGTH      = 3'd3,
        KIND_SIGNAL_PAIR = 3'd4,
        KIND_END_OK      = 3'd5,
        KIND_END_MISSING = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [31:0] low;
        logic [31:0] index;
    } result_t;

endpackage

@@ hdl/icfp_if.sv @@
interface icfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface icfp_field_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_kind;
    logic [31:0] field_value;
    logic [31:0] low_duration;
    logic [31:0] pair_number;

    modport source (
        output valid, output field_kind, output field_value,
        output low_duration, output pair_number, input ready
    );
    modport sink (
        input valid, input field_kind, input field_value,
        input low_duration, input pair_number, output ready
    );
endinterface

@@ hdl/icfp_skid.sv @@
module icfp_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  icfp_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output icfp_pkg::result_t out_data
);
    import icfp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    assign take = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // drain the skid slot into the output register
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds an item while the output register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("item pushed while both slots are full");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid slot lost its item while the output stalled");

endmodule

@@ hdl/ir_command_frame_parser.sv @@
// Each result is registered in the output buffer before it reaches field_out.
// Throughput: one byte per cycle while the skid slot is free; the per-byte
// state update is a single register stage, and a two-slot output buffer
// keeps bytes flowing while one result waits on field_out.
// Reset (rst_n low, asynchronous): parser expects the first version byte,
// length and pair counters clear, output buffer empties.
module ir_command_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    icfp_byte_if.sink    frame_in,
    icfp_field_if.source field_out
);
    import icfp_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [31:0] held_reg;
    logic [31:0] held_next;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic [31:0] done_reg;
    logic [31:0] done_next;
    logic        low_half_reg;
    logic        low_half_next;

    logic        accept;
    logic        produce;
    result_t     res;
    result_t     out_data;
    logic        buf_ready;
    logic [7:0]  b;
    logic [31:0] shifted;
    logic        last;
    logic [1:0]  pos_adv;
    logic [31:0] done_inc;

    assign b        = frame_in.data_byte;
    assign accept   = frame_in.valid && buf_ready;
    assign shifted  = {word_reg[23:0], b};
    assign last     = (pos_reg == 2'd3);
    assign pos_adv  = pos_reg + 2'd1;
    assign done_inc = done_reg + 32'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        word_next     = word_reg;
        held_next     = held_reg;
        total_next    = total_reg;
        done_next     = done_reg;
        low_half_next = low_half_reg;
        produce       = 1'b0;
        res           = '{kind: KIND_VERSION, value: 32'd0, low: 32'd0, index: 32'd0};
        case (phase_reg)
            PH_KEY_D, PH_KEY_F, PH_KEY_L, PH_KEY_S:
            begin
                // test the byte against this key and every later one
                if (phase_reg == PH_KEY_D && b == CH_DUTY)
                begin
                    phase_next = PH_DUTY;
                    pos_next   = 2'd0;
                    word_next  = 32'd0;
                end
                else if ((phase_reg == PH_KEY_D || phase_reg == PH_KEY_F)
                         && b == CH_FREQ)
                begin
                    phase_next = PH_FREQ;
                    pos_next   = 2'd0;
                    word_next  = 32'd0;
                end
                else if (phase_reg != PH_KEY_S && b == CH_LEN)
                begin
                    phase_next = PH_LEN;
                    pos_next   = 2'd0;
                    word_next  = 32'd0;
                end
                else if (b == CH_SIG && total_reg != 32'd0)
                begin
                    phase_next    = PH_PAIRS;
                    pos_next      = 2'd0;
                    word_next     = 32'd0;
                    done_next     = 32'd0;
                    low_half_next = 1'b0;
                end
                else
                begin
                    phase_next = PH_END;
                end
            end
            PH_DUTY, PH_FREQ, PH_LEN:
            begin
                word_next = shifted;
                pos_next  = last ? 2'd0 : pos_adv;
                if (last)
                begin
                    produce   = 1'b1;
                    res.value = shifted;
                    if (phase_reg == PH_DUTY)
                    begin
                        phase_next = PH_KEY_F;
                        res.kind   = KIND_DUTY;
                    end
                    else if (phase_reg == PH_FREQ)
                    begin
                        phase_next = PH_KEY_L;
                        res.kind   = KIND_FREQUENCY;
                    end
                    else
                    begin
                        phase_next = PH_KEY_S;
                        total_next = shifted;
                        res.kind   = KIND_LENGTH;
                    end
                end
            end
            PH_PAIRS:
            begin
                word_next = shifted;
                pos_next  = last ? 2'd0 : pos_adv;
                if (last)
                begin
                    word_next = 32'd0;
                    if (!low_half_reg)
                    begin
                        held_next     = shifted;
                        low_half_next = 1'b1;
                    end
                    else
                    begin
                        low_half_next = 1'b0;
                        done_next     = done_inc;
                        if (done_inc == total_reg)
                        begin
                            phase_next = PH_END;
                        end
                        produce   = 1'b1;
                        res.kind  = KIND_SIGNAL_PAIR;
                        res.value = held_reg;
                        res.low   = shifted;
                        res.index = done_reg;
                    end
                end
            end
            PH_END:
            begin
                // rearm for the next frame
                phase_next    = PH_VER;
                pos_next      = 2'd0;
                word_next     = 32'd0;
                total_next    = 32'd0;
                done_next     = 32'd0;
                low_half_next = 1'b0;
                held_next     = 32'd0;
                produce       = 1'b1;
                res.kind      = (b == CH_ETX) ? KIND_END_OK : KIND_END_MISSING;
            end
            PH_VER:
            begin
                word_next = shifted;
                pos_next  = last ? 2'd0 : pos_adv;
                if (last)
                begin
                    phase_next = PH_KEY_D;
                    produce    = 1'b1;
                    res.kind   = KIND_VERSION;
                    res.value  = shifted;
                end
            end
            default:
            begin
                // unknown phase: restart with this byte as first version byte
                phase_next = PH_VER;
                word_next  = {24'd0, b};
                pos_next   = 2'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_VER;
            pos_reg      <= 2'd0;
            word_reg     <= 32'd0;
            held_reg     <= 32'd0;
            total_reg    <= 32'd0;
            done_reg     <= 32'd0;
            low_half_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            word_reg     <= word_next;
            held_reg     <= held_next;
            total_reg    <= total_next;
            done_reg     <= done_next;
            low_half_reg <= low_half_next;
        end
    end

    icfp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && produce),
        .push_data (res),
        .ready     (buf_ready),
        .out_valid (field_out.valid),
        .out_ready (field_out.ready),
        .out_data  (out_data)
    );

    assign frame_in.ready         = buf_ready;
    assign field_out.field_kind   = out_data.kind;
    assign field_out.field_value  = out_data.value;
    assign field_out.low_duration = out_data.low;
    assign field_out.pair_number  = out_data.index;

    a_low_half_in_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        low_half_reg |-> (phase_reg == PH_PAIRS))
        else $error("low half flag set outside the pair phase");

    a_pairs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAIRS) |-> (done_reg < total_reg))
        else $error("pair count reached the length while still reading pairs");

    a_pos_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 2'd0) |-> (phase_reg == PH_VER || phase_reg == PH_DUTY
            || phase_reg == PH_FREQ || phase_reg == PH_LEN || phase_reg == PH_PAIRS))
        else $error("byte position left nonzero outside a word phase");

endmodule

@@ verif/icfp_field_checker.sv @@
module icfp_field_checker (
    input  logic   clk,
    input  logic   rst_n,
    icfp_byte_if   frame_mon,
    icfp_field_if  field_mon,
    output int     fail_count,
    output int     pending_fields
);
    import icfp_pkg::*;

    phase_t      phase;
    logic [1:0]  byte_pos;
    logic [31:0] word_acc;
    logic [31:0] high_hold;
    logic [31:0] pair_limit;
    logic [31:0] pair_count;
    logic        reading_low;

    result_t     expected_fields[$];
    result_t     want;
    int          mismatches = 0;
    int          waiting = 0;

    assign fail_count     = mismatches;
    assign pending_fields = waiting;

    function automatic bit shift_byte(input logic [7:0] b);
        word_acc = {word_acc[23:0], b};
        if (byte_pos == 2'd3)
        begin
            byte_pos = 2'd0;
            return 1'b1;
        end
        byte_pos = byte_pos + 2'd1;
        return 1'b0;
    endfunction

    function automatic void open_word(input phase_t next);
        phase    = next;
        byte_pos = 2'd0;
        word_acc = 32'd0;
    endfunction

    function automatic void add_field(input kind_t k, input logic [31:0] v,
                                      input logic [31:0] lo, input logic [31:0] idx);
        result_t r;
        r.kind  = k;
        r.value = v;
        r.low   = lo;
        r.index = idx;
        expected_fields.push_back(r);
    endfunction

    function automatic void clear_parser();
        open_word(PH_VER);
        high_hold   = 32'd0;
        pair_limit  = 32'd0;
        pair_count  = 32'd0;
        reading_low = 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [31:0] idx;
        case (phase)
            PH_KEY_D, PH_KEY_F, PH_KEY_L, PH_KEY_S:
            begin
                // test against this key and every later one; no match ends the frame
                if (phase <= PH_KEY_D && b == CH_DUTY)
                    open_word(PH_DUTY);
                else if (phase <= PH_KEY_F && b == CH_FREQ)
                    open_word(PH_FREQ);
                else if (phase <= PH_KEY_L && b == CH_LEN)
                    open_word(PH_LEN);
                else if (b == CH_SIG && pair_limit != 32'd0)
                begin
                    open_word(PH_PAIRS);
                    pair_count  = 32'd0;
                    reading_low = 1'b0;
                end
                else
                    phase = PH_END;
            end
            PH_DUTY:
            begin
                if (shift_byte(b))
                begin
                    phase = PH_KEY_F;
                    add_field(KIND_DUTY, word_acc, 32'd0, 32'd0);
                end
            end
            PH_FREQ:
            begin
                if (shift_byte(b))
                begin
                    phase = PH_KEY_L;
                    add_field(KIND_FREQUENCY, word_acc, 32'd0, 32'd0);
                end
            end
            PH_LEN:
            begin
                if (shift_byte(b))
                begin
                    pair_limit = word_acc;
                    phase      = PH_KEY_S;
                    add_field(KIND_LENGTH, word_acc, 32'd0, 32'd0);
                end
            end
            PH_PAIRS:
            begin
                if (shift_byte(b))
                begin
                    if (!reading_low)
                    begin
                        high_hold   = word_acc;
                        reading_low = 1'b1;
                        word_acc    = 32'd0;
                    end
                    else
                    begin
                        reading_low = 1'b0;
                        idx         = pair_count;
                        pair_count  = pair_count + 32'd1;
                        if (pair_count == pair_limit)
                            phase = PH_END;
                        add_field(KIND_SIGNAL_PAIR, high_hold, word_acc, idx);
                        word_acc = 32'd0;
                    end
                end
            end
            PH_END:
            begin
                clear_parser();
                add_field((b == CH_ETX) ? KIND_END_OK : KIND_END_MISSING,
                          32'd0, 32'd0, 32'd0);
            end
            default:
            begin
                if (phase != PH_VER)
                    open_word(PH_VER);
                if (shift_byte(b))
                begin
                    phase = PH_KEY_D;
                    add_field(KIND_VERSION, word_acc, 32'd0, 32'd0);
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_fields.delete();
        end
        else
        begin
            if (frame_mon.valid && frame_mon.ready)
                decode_byte(frame_mon.data_byte);
            if (field_mon.valid && field_mon.ready)
            begin
                if (expected_fields.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected field: kind %0d value %h low %h index %0d",
                                 field_mon.field_kind, field_mon.field_value,
                                 field_mon.low_duration, field_mon.pair_number);
                    mismatches++;
                end
                else
                begin
                    want = expected_fields.pop_front();
                    if (field_mon.field_kind !== want.kind
                        || field_mon.field_value !== want.value
                        || field_mon.low_duration !== want.low
                        || field_mon.pair_number !== want.index)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("field mismatch: expected kind %0d value %h low %h index %0d",
                                     want.kind, want.value, want.low, want.index);
                            $display("                got      kind %0d value %h low %h index %0d",
                                     field_mon.field_kind, field_mon.field_value,
                                     field_mon.low_duration, field_mon.pair_number);
                        end
                        mismatches++;
                    end
                end
            end
        end
        waiting = expected_fields.size();
    end

endmodule

@@ verif/tb_ir_command_frame_parser.sv @@
module tb_ir_command_frame_parser;
    import icfp_pkg::*;

    localparam int PHASE_BYTES = 470;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   bytes_sent;
    int   fail_count;
    int   pending_fields;

    icfp_byte_if  frame_in ();
    icfp_field_if field_out ();

    ir_command_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_in  (frame_in),
        .field_out (field_out)
    );

    icfp_field_checker field_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_mon      (frame_in),
        .field_mon      (field_out),
        .fail_count     (fail_count),
        .pending_fields (pending_fields)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

    always @(negedge clk)
        field_out.ready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            frame_in.valid <= 1'b0;
            @(negedge clk);
        end
        frame_in.valid     <= 1'b1;
        frame_in.data_byte <= b;
        do
            @(posedge clk);
        while (!frame_in.ready);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[i*8 +: 8]);
    endtask

    // hold the sender until every outstanding field has come out
    task automatic drain_fields();
        @(negedge clk);
        frame_in.valid <= 1'b0;
        while (pending_fields != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 | $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_DUTY || b == CH_FREQ || b == CH_LEN || b == CH_SIG);
        return b;
    endfunction

    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(0, 9))
            0: return CH_ETX;
            1: return CH_DUTY;
            2: return CH_FREQ;
            3: return CH_LEN;
            4: return CH_SIG;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame();
        logic [31:0] len;
        bit          with_sig;
        send_word(pick_word());
        if ($urandom_range(0, 99) < 60)
        begin
            send_byte(CH_DUTY);
            send_word(pick_word());
        end
        if ($urandom_range(0, 99) < 60)
        begin
            send_byte(CH_FREQ);
            send_word(pick_word());
        end
        with_sig = ($urandom_range(0, 99) < 75);
        len      = 32'd0;
        if ($urandom_range(0, 99) < 70)
        begin
            // keep pair counts small; huge lengths only where no pairs follow
            len = with_sig ? 32'($urandom_range(0, 3)) : pick_word();
            send_byte(CH_LEN);
            send_word(len);
        end
        if (with_sig)
        begin
            send_byte(CH_SIG);
            for (int p = 0; p < int'(len); p++)
            begin
                send_word(pick_word());
                send_word(pick_word());
            end
        end
        else
            send_byte(pick_plain_byte());
        send_byte(($urandom_range(0, 99) < 88) ? CH_ETX : 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n)
            send_byte(pick_noise_byte());
    endtask

    initial
    begin
        rst_n              = 1'b0;
        frame_in.valid     = 1'b0;
        frame_in.data_byte = 8'd0;
        idle_pct           = 8;
        stall_pct          = 66;
        bytes_sent         = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 8;
                    stall_pct = 66;
                end
                1:
                begin
                    idle_pct  = 66;
                    stall_pct = 8;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            if (ph == 0)
            begin
                // extreme duty and frequency, 's' with no length, bad end byte
                send_word(32'hFFFF_FFFF);
                send_byte(CH_DUTY);
                send_word(32'h0000_0000);
                send_byte(CH_FREQ);
                send_word(32'hFFFF_FFFF);
                send_byte(CH_SIG);
                send_byte(8'hFF);
                // one pair with extreme times, clean end
                send_word(32'h0000_0000);
                send_byte(CH_LEN);
                send_word(32'd1);
                send_byte(CH_SIG);
                send_word(32'hFFFF_FFFF);
                send_word(32'h0000_0000);
                send_byte(CH_ETX);
            end
            while (bytes_sent < (ph + 1) * PHASE_BYTES)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_frame();
                else
                    send_noise();
            end
            drain_fields();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_fields == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/icfp_pkg.sv
hdl/icfp_if.sv
hdl/icfp_skid.sv
hdl/ir_command_frame_parser.sv
verif/icfp_field_checker.sv
verif/tb_ir_command_frame_parser.sv
